### src/gobd_pkg.sv
package gobd_pkg;

   // Image geometry and pixel depth.
   localparam int IMAGE_WIDTH  = 1024;
   localparam int IMAGE_HEIGHT = 1024;
   localparam int PIXEL_BITS   = 8;

   // Field widths.
   localparam int PIXEL_W     = 8;
   localparam int COORD_W     = 10;
   localparam int SIZE_W      = 9;
   localparam int SUM_W       = 28;
   localparam int EDGE_W      = 12;
   localparam int IMG_CMP_W   = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 28;
   localparam int NUM_CELLS   = 9;
   localparam int CELL_W      = 4;
   localparam int ACTION_W    = 2;
   localparam int PATTERN_W   = 3;

   // Result queue depth; a power of two so that the pointers wrap naturally.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [PIXEL_W-1:0] PIXEL_MASK = PIXEL_W'((64'd1 << PIXEL_BITS) - 64'd1);
   localparam logic [SUM_W-1:0]   SUM_MAX    = '1;

   // Register reset values.
   localparam logic [COORD_W-1:0] RST_GRID_LEFT   = 10'd15;
   localparam logic [COORD_W-1:0] RST_GRID_TOP    = 10'd40;
   localparam logic [SIZE_W-1:0]  RST_CELL_WIDTH  = 9'd215;
   localparam logic [SIZE_W-1:0]  RST_CELL_HEIGHT = 9'd50;
   localparam logic [SUM_W-1:0]   RST_MIDDLE_THR  = 28'd160;
   localparam logic [SUM_W-1:0]   RST_SIDE_THR    = 28'd1500;
   localparam logic [SUM_W-1:0]   RST_HARD_THR    = 28'd4100;

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_LEFT   = 3'd0,
      CSR_GRID_TOP    = 3'd1,
      CSR_CELL_WIDTH  = 3'd2,
      CSR_CELL_HEIGHT = 3'd3,
      CSR_MIDDLE_THR  = 3'd4,
      CSR_SIDE_THR    = 3'd5,
      CSR_HARD_THR    = 3'd6
   } csr_index_type;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_STRAIGHT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SPIN     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STEER    = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               frame_end;
   } req_payload_type;

   typedef struct packed {
      logic [NUM_CELLS-1:0] occupancy_map;
      logic [ACTION_W-1:0]  action;
      logic [PATTERN_W-1:0] pattern;
      logic                 hard_obstacle;
   } rsp_payload_type;

   // Grid edges and thresholds as seen by the datapath.
   typedef struct packed {
      logic [EDGE_W-1:0] col_edge0;
      logic [EDGE_W-1:0] col_edge1;
      logic [EDGE_W-1:0] col_edge2;
      logic [EDGE_W-1:0] col_edge3;
      logic [EDGE_W-1:0] row_edge0;
      logic [EDGE_W-1:0] row_edge1;
      logic [EDGE_W-1:0] row_edge2;
      logic [EDGE_W-1:0] row_edge3;
      logic [SUM_W-1:0]  middle_threshold;
      logic [SUM_W-1:0]  side_threshold;
      logic [SUM_W-1:0]  hard_threshold;
   } cfg_type;

   // A located pixel on its way to the accumulators.
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [CELL_W-1:0]  slot;
      logic [PIXEL_W-1:0] pixel;
      logic               frame_end;
   } cell_item_type;

   // A decision on its way to the result queue.
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } decision_type;

endpackage

### src/gobd_csr.sv
module gobd_csr
   import gobd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   logic [COORD_W-1:0] grid_left_ff, grid_left_in;
   logic [COORD_W-1:0] grid_top_ff, grid_top_in;
   logic [SIZE_W-1:0]  cell_width_ff, cell_width_in;
   logic [SIZE_W-1:0]  cell_height_ff, cell_height_in;
   logic [SUM_W-1:0]   middle_thr_ff, middle_thr_in;
   logic [SUM_W-1:0]   side_thr_ff, side_thr_in;
   logic [SUM_W-1:0]   hard_thr_ff, hard_thr_in;
   cfg_type            cfg_ff, cfg_in;

   // The port takes a write in every cycle.
   assign csr_ready = 1'b1;

   // Register write decode; unknown indexes are dropped.
   always_comb begin
      grid_left_in   = grid_left_ff;
      grid_top_in    = grid_top_ff;
      cell_width_in  = cell_width_ff;
      cell_height_in = cell_height_ff;
      middle_thr_in  = middle_thr_ff;
      side_thr_in    = side_thr_ff;
      hard_thr_in    = hard_thr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_LEFT:   grid_left_in   = csr_data[COORD_W-1:0];
            CSR_GRID_TOP:    grid_top_in    = csr_data[COORD_W-1:0];
            CSR_CELL_WIDTH:  cell_width_in  = csr_data[SIZE_W-1:0];
            CSR_CELL_HEIGHT: cell_height_in = csr_data[SIZE_W-1:0];
            CSR_MIDDLE_THR:  middle_thr_in  = csr_data[SUM_W-1:0];
            CSR_SIDE_THR:    side_thr_in    = csr_data[SUM_W-1:0];
            CSR_HARD_THR:    hard_thr_in    = csr_data[SUM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_left_ff   <= RST_GRID_LEFT;
         grid_top_ff    <= RST_GRID_TOP;
         cell_width_ff  <= RST_CELL_WIDTH;
         cell_height_ff <= RST_CELL_HEIGHT;
         middle_thr_ff  <= RST_MIDDLE_THR;
         side_thr_ff    <= RST_SIDE_THR;
         hard_thr_ff    <= RST_HARD_THR;
      end else begin
         grid_left_ff   <= grid_left_in;
         grid_top_ff    <= grid_top_in;
         cell_width_ff  <= cell_width_in;
         cell_height_ff <= cell_height_in;
         middle_thr_ff  <= middle_thr_in;
         side_thr_ff    <= side_thr_in;
         hard_thr_ff    <= hard_thr_in;
      end
   end

   // Cell edges along each axis, kept in registers so the datapath only compares.
   always_comb begin
      cfg_in.col_edge0 = EDGE_W'(grid_left_ff);
      cfg_in.col_edge1 = EDGE_W'(grid_left_ff) + EDGE_W'(cell_width_ff);
      cfg_in.col_edge2 = EDGE_W'(grid_left_ff) + EDGE_W'({cell_width_ff, 1'b0});
      cfg_in.col_edge3 = cfg_in.col_edge2 + EDGE_W'(cell_width_ff);
      cfg_in.row_edge0 = EDGE_W'(grid_top_ff);
      cfg_in.row_edge1 = EDGE_W'(grid_top_ff) + EDGE_W'(cell_height_ff);
      cfg_in.row_edge2 = EDGE_W'(grid_top_ff) + EDGE_W'({cell_height_ff, 1'b0});
      cfg_in.row_edge3 = cfg_in.row_edge2 + EDGE_W'(cell_height_ff);
      cfg_in.middle_threshold = middle_thr_ff;
      cfg_in.side_threshold   = side_thr_ff;
      cfg_in.hard_threshold   = hard_thr_ff;
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

### src/gobd_locate.sv
module gobd_locate
   import gobd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  cfg_type         cfg,
   output cell_item_type   item
);

   logic            s0_valid_ff, s0_valid_in;
   req_payload_type s0_payload_ff;
   logic            col_in_image;
   logic            row_in_image;
   logic [2:0]      col_cell;
   logic [2:0]      row_cell;
   cell_item_type   item_ff, item_in;

   // Returns {inside, index} for one axis of the grid.
   function automatic logic [2:0] axis_cell(
      input logic [EDGE_W-1:0] pos,
      input logic [EDGE_W-1:0] edge0,
      input logic [EDGE_W-1:0] edge1,
      input logic [EDGE_W-1:0] edge2,
      input logic [EDGE_W-1:0] edge3
   );
      logic [2:0] code;
      if (pos < edge0) begin
         code = 3'b000;
      end else if (pos < edge1) begin
         code = 3'b100;
      end else if (pos < edge2) begin
         code = 3'b101;
      end else if (pos < edge3) begin
         code = 3'b110;
      end else begin
         code = 3'b000;
      end
      return code;
   endfunction

   // Input register.
   assign s0_valid_in = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_valid_in) begin
         s0_payload_ff <= req_payload;
      end
   end

   // Find the grid cell that the pixel falls in.
   always_comb begin
      col_in_image = IMG_CMP_W'(s0_payload_ff.column) < IMG_CMP_W'(IMAGE_WIDTH);
      row_in_image = IMG_CMP_W'(s0_payload_ff.row) < IMG_CMP_W'(IMAGE_HEIGHT);
      col_cell = axis_cell(EDGE_W'(s0_payload_ff.column), cfg.col_edge0, cfg.col_edge1,
                           cfg.col_edge2, cfg.col_edge3);
      row_cell = axis_cell(EDGE_W'(s0_payload_ff.row), cfg.row_edge0, cfg.row_edge1,
                           cfg.row_edge2, cfg.row_edge3);
      item_in.valid     = s0_valid_ff;
      item_in.hit       = col_in_image && row_in_image && col_cell[2] && row_cell[2];
      item_in.slot      = CELL_W'({row_cell[1:0], 1'b0}) + CELL_W'(row_cell[1:0])
                          + CELL_W'(col_cell[1:0]);
      item_in.pixel     = s0_payload_ff.pixel & PIXEL_MASK;
      item_in.frame_end = s0_payload_ff.frame_end;
   end

   // Located item register; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.hit       <= item_in.hit;
      item_ff.slot      <= item_in.slot;
      item_ff.pixel     <= item_in.pixel;
      item_ff.frame_end <= item_in.frame_end;
   end

   assign item = item_ff;

endmodule

### src/gobd_accum.sv
module gobd_accum
   import gobd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_item_type item,
   input  cfg_type       cfg,
   output decision_type  decision
);

   logic [SUM_W-1:0]     sums_ff [NUM_CELLS];
   logic [SUM_W-1:0]     sums_in [NUM_CELLS];
   logic                 decide_ff, decide_in;
   logic [NUM_CELLS-1:0] occupied;
   logic [PATTERN_W-1:0] row_pattern [3];
   logic                 hard;

   function automatic logic side_case(input logic [PATTERN_W-1:0] p);
      return (p >= 3'd1 && p <= 3'd4) || p == 3'd6;
   endfunction

   // Saturating accumulate. The cycle after a frame end the sums are read for
   // the decision and restart from zero, so the next pixel adds onto zero.
   always_comb begin
      logic [SUM_W-1:0] base;
      logic [SUM_W:0]   total;
      for (int i = 0; i < NUM_CELLS; i++) begin
         base  = decide_ff ? '0 : sums_ff[i];
         total = {1'b0, base} + (SUM_W + 1)'(item.pixel);
         if (item.valid && item.hit && item.slot == CELL_W'(i)) begin
            sums_in[i] = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
         end else begin
            sums_in[i] = base;
         end
      end
      decide_in = item.valid && item.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CELLS; i++) begin
            sums_ff[i] <= '0;
         end
         decide_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_CELLS; i++) begin
            sums_ff[i] <= sums_in[i];
         end
         decide_ff <= decide_in;
      end
   end

   // Occupancy per cell; middle-column cells also pass on the middle threshold.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_pattern[r] = '0;
         for (int c = 0; c < 3; c++) begin
            occupied[r*3+c] = (sums_ff[r*3+c] >= cfg.side_threshold)
                              || (c == 1 && sums_ff[r*3+c] >= cfg.middle_threshold);
            row_pattern[r][2-c] = occupied[r*3+c];
         end
      end
      hard = (sums_ff[NUM_CELLS-1] >= cfg.side_threshold)
             && (sums_ff[NUM_CELLS-1] >= cfg.hard_threshold);
   end

   // Action choice: the bottom row decides first, then the middle, then the top.
   always_comb begin
      decision.valid                 = decide_ff;
      decision.payload.occupancy_map = occupied;
      decision.payload.hard_obstacle = hard;
      decision.payload.action        = ACT_STRAIGHT;
      decision.payload.pattern       = '0;
      if (occupied == '0) begin
         decision.payload.action = ACT_STRAIGHT;
      end else if (row_pattern[2] == 3'd5 || row_pattern[2] == 3'd7) begin
         decision.payload.action = ACT_SPIN;
      end else if (side_case(row_pattern[2])) begin
         decision.payload.action  = ACT_STEER;
         decision.payload.pattern = row_pattern[2];
      end else if (side_case(row_pattern[1])) begin
         decision.payload.pattern = row_pattern[1];
      end else if (side_case(row_pattern[0])) begin
         decision.payload.pattern = row_pattern[0];
      end
   end

endmodule

### src/gobd_rsp_queue.sv
module gobd_rsp_queue
   import gobd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_frame_end,
   output logic            req_stall,
   input  decision_type    decision,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   rsp_payload_type        entries_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [RSP_CNT_W-1:0]   pending_ff, pending_in;
   logic                   req_take;
   logic                   rsp_take;
   logic                   frame_take;

   // Frame ends in flight plus results waiting never exceed the queue depth, so a
   // decision always finds a free entry; pixels are held while that count is at the depth.
   assign req_stall  = pending_ff == RSP_CNT_W'(RSP_DEPTH);
   assign req_take   = req_valid && !req_stall;
   assign frame_take = req_take && req_frame_end;
   assign rsp_valid  = count_ff != '0;
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign rsp_payload = entries_ff[rd_ptr_ff];

   always_comb begin
      pending_in = pending_ff + RSP_CNT_W'(frame_take) - RSP_CNT_W'(rsp_take);
      count_in   = count_ff + RSP_CNT_W'(decision.valid) - RSP_CNT_W'(rsp_take);
      wr_ptr_in  = wr_ptr_ff + RSP_PTR_W'(decision.valid);
      rd_ptr_in  = rd_ptr_ff + RSP_PTR_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         count_ff   <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (decision.valid) begin
         entries_ff[wr_ptr_ff] <= decision.payload;
      end
   end

endmodule

### src/grid_obstacle_detector.sv
// A frame-end transaction passes the input register, the located item register and the
// decide register, and its result is written into the result queue before rsp offers it.
// Throughput: one pixel per cycle; the input stalls only while four results are
// pending (in flight or waiting in the four-entry result queue).
// Reset is synchronous and active high: registers return to defaults, sums to zero.
module grid_obstacle_detector
   import gobd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type       cfg;
   cell_item_type item;
   decision_type  decision;

   // Configuration registers and derived grid edges.
   gobd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Input register and cell lookup.
   gobd_locate u_locate (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg),
      .item        (item)
   );

   // Cell sums and the frame decision.
   gobd_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .cfg      (cfg),
      .decision (decision)
   );

   // Result queue and input flow control.
   gobd_rsp_queue u_rsp_queue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_payload.frame_end),
      .req_stall     (req_stall),
      .decision      (decision),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

endmodule

### src/gobd_checker.sv
module gobd_checker
   import gobd_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // A stalled result transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // The hard flag needs the bottom-right cell to be occupied.
   a_hard_needs_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.hard_obstacle |-> rsp_payload.occupancy_map[NUM_CELLS-1])
      else $error("hard obstacle without bottom-right occupancy");

   // Spinning and going straight on an empty grid carry no pattern.
   a_no_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.action == ACT_SPIN || rsp_payload.occupancy_map == '0)
      |-> rsp_payload.pattern == '0)
      else $error("pattern given where none applies");

   // Steering reports the bottom row, left cell in the top bit.
   a_steer_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.action == ACT_STEER
      |-> rsp_payload.pattern == {rsp_payload.occupancy_map[6], rsp_payload.occupancy_map[7],
                                  rsp_payload.occupancy_map[8]})
      else $error("steer pattern does not match bottom row");

   // The unused action code never appears.
   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.action != ACT_UNUSED)
      else $error("invalid action code");

endmodule

bind grid_obstacle_detector gobd_checker u_checker (.*);

### tb/sv/grid_obstacle_detector_tb.sv
module grid_obstacle_detector_tb;
   import gobd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 100000;
   localparam int TAIL_CYCLES    = 8;
   localparam int LONG_HOLD      = 300;
   localparam int RANDOM_PHASES  = 12;
   localparam int PRESSURE_PHASE = 2;
   localparam int CALM_PHASES    = 2;
   localparam int PHASE_ITEMS    = 75;

   // Index that decodes to no register; writes to it must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_SUCH_REG = 3'd7;

   // Row patterns that make the robot spin instead of steering.
   localparam logic [PATTERN_W-1:0] PAT_OUTER = 3'b101;
   localparam logic [PATTERN_W-1:0] PAT_FULL  = 3'b111;

   typedef struct packed {
      logic [COORD_W-1:0] grid_left;
      logic [COORD_W-1:0] grid_top;
      logic [SIZE_W-1:0]  cell_width;
      logic [SIZE_W-1:0]  cell_height;
      logic [SUM_W-1:0]   middle_thr;
      logic [SUM_W-1:0]   side_thr;
      logic [SUM_W-1:0]   hard_thr;
   } grid_setting_type;

   // Mirror of the cell sums and registers; queues the decision each frame end makes.
   class grid_tally;
      logic [COORD_W-1:0] grid_left;
      logic [COORD_W-1:0] grid_top;
      logic [SIZE_W-1:0]  cell_width;
      logic [SIZE_W-1:0]  cell_height;
      logic [SUM_W-1:0]   middle_thr;
      logic [SUM_W-1:0]   side_thr;
      logic [SUM_W-1:0]   hard_thr;
      logic [SUM_W-1:0]   cell_sum [NUM_CELLS];
      rsp_payload_type    pending_decisions [$];
      int                 mismatch_count;

      function new();
         grid_left      = RST_GRID_LEFT;
         grid_top       = RST_GRID_TOP;
         cell_width     = RST_CELL_WIDTH;
         cell_height    = RST_CELL_HEIGHT;
         middle_thr     = RST_MIDDLE_THR;
         side_thr       = RST_SIDE_THR;
         hard_thr       = RST_HARD_THR;
         mismatch_count = 0;
         foreach (cell_sum[i]) cell_sum[i] = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_GRID_LEFT:   grid_left   = data[COORD_W-1:0];
            CSR_GRID_TOP:    grid_top    = data[COORD_W-1:0];
            CSR_CELL_WIDTH:  cell_width  = data[SIZE_W-1:0];
            CSR_CELL_HEIGHT: cell_height = data[SIZE_W-1:0];
            CSR_MIDDLE_THR:  middle_thr  = data[SUM_W-1:0];
            CSR_SIDE_THR:    side_thr    = data[SUM_W-1:0];
            CSR_HARD_THR:    hard_thr    = data[SUM_W-1:0];
            default: ;
         endcase
      endfunction

      // Cell 0..2 along one axis, or -1 when the position misses the grid.
      static function int axis_slot(int unsigned pos, int unsigned origin, int unsigned size);
         int unsigned d;
         if (pos < origin) return -1;
         d = pos - origin;
         if (d < size) return 0;
         if (d < 2 * size) return 1;
         if (d < 3 * size) return 2;
         return -1;
      endfunction

      // A pattern that is neither empty nor one of the spin patterns, which a row can steer around.
      static function bit one_sided(logic [PATTERN_W-1:0] p);
         return p != '0 && p != PAT_OUTER && p != PAT_FULL;
      endfunction

      function void note_pixel(req_payload_type p);
         int                   cx;
         int                   cy;
         logic [SUM_W:0]       total;
         logic [PATTERN_W-1:0] pat [3];
         rsp_payload_type      d;

         // Accumulate the pixel into its cell, saturating the sum.
         cx = axis_slot(p.column, grid_left, cell_width);
         cy = axis_slot(p.row, grid_top, cell_height);
         if (p.column < IMAGE_WIDTH && p.row < IMAGE_HEIGHT && cx >= 0 && cy >= 0) begin
            total = {1'b0, cell_sum[cy * 3 + cx]} + (SUM_W + 1)'(p.pixel & PIXEL_MASK);
            cell_sum[cy * 3 + cx] = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
         end
         if (!p.frame_end) return;

         // Judge each cell; the middle column also passes on its own middle threshold.
         d = '0;
         for (int r = 0; r < 3; r++) begin
            pat[r] = '0;
            for (int c = 0; c < 3; c++) begin
               if (cell_sum[r * 3 + c] >= side_thr ||
                   (c == 1 && cell_sum[r * 3 + c] >= middle_thr)) begin
                  d.occupancy_map[r * 3 + c] = 1'b1;
                  pat[r][2 - c] = 1'b1;
               end
            end
         end
         d.hard_obstacle = cell_sum[8] >= side_thr && cell_sum[8] >= hard_thr;

         // The bottom row decides first, then the middle and the top rows.
         d.action = ACT_STRAIGHT;
         if (d.occupancy_map == '0) begin
            d.action = ACT_STRAIGHT;
         end else if (pat[2] == PAT_OUTER || pat[2] == PAT_FULL) begin
            d.action = ACT_SPIN;
         end else if (one_sided(pat[2])) begin
            d.action  = ACT_STEER;
            d.pattern = pat[2];
         end else if (one_sided(pat[1])) begin
            d.pattern = pat[1];
         end else if (one_sided(pat[0])) begin
            d.pattern = pat[0];
         end

         pending_decisions.insert(pending_decisions.size(), d);
         foreach (cell_sum[i]) cell_sum[i] = '0;
      endfunction

      function void check_decision(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_decisions.size() == 0) begin
            $error("result transaction with no frame pending: %h", got);
            mismatch_count++;
            return;
         end
         want = pending_decisions.pop_front();
         if (got.occupancy_map !== want.occupancy_map) begin
            $error("occupancy_map: expected %h, actual %h", want.occupancy_map,
                   got.occupancy_map);
            mismatch_count++;
         end
         if (got.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, got.action);
            mismatch_count++;
         end
         if (got.pattern !== want.pattern) begin
            $error("pattern: expected %0d, actual %0d", want.pattern, got.pattern);
            mismatch_count++;
         end
         if (got.hard_obstacle !== want.hard_obstacle) begin
            $error("hard_obstacle: expected %0d, actual %0d", want.hard_obstacle,
                   got.hard_obstacle);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   grid_tally        tally;
   grid_setting_type active_setting;
   bit               calm_tail = 1'b0;
   bit               hold_request = 1'b0;
   int               cycle_count = 0;

   grid_obstacle_detector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[grid_obstacle_detector] ERROR");
         $finish;
      end
   end

   // Compare every result transaction taken at this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tally.check_decision(rsp_payload);
   end

   // Result side: random stall bursts, plus one long hold-off that backs up the block.
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (int n = 0; n < LONG_HOLD; n++) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_payload_type pixel_at(int pix, int col, int row, bit last);
      req_payload_type p;
      p.pixel     = PIXEL_W'(pix);
      p.column    = COORD_W'(col);
      p.row       = COORD_W'(row);
      p.frame_end = last;
      return p;
   endfunction

   // Mostly lands on or just around the grid, sometimes anywhere in the image.
   function automatic logic [COORD_W-1:0] pick_coord(int origin, int size);
      if ($urandom_range(0, 9) == 0) return COORD_W'($urandom_range(0, 1023));
      return COORD_W'(origin + int'($urandom_range(0, 3 * size + 1)) - 1);
   endfunction

   function automatic req_payload_type random_pixel(grid_setting_type s, bit last);
      req_payload_type p;
      p.column    = pick_coord(s.grid_left, s.cell_width);
      p.row       = pick_coord(s.grid_top, s.cell_height);
      p.frame_end = last;
      case ($urandom_range(0, 5))
         0:       p.pixel = '0;
         1:       p.pixel = '1;
         default: p.pixel = PIXEL_W'($urandom_range(0, 255));
      endcase
      return p;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return SIZE_W'(1);
         2, 3:    return SIZE_W'(341);
         default: return SIZE_W'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic [SUM_W-1:0] pick_threshold(int span);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return SUM_MAX;
         default: return SUM_W'($urandom_range(0, span));
      endcase
   endfunction

   function automatic grid_setting_type pick_setting();
      grid_setting_type s;
      s.grid_left   = COORD_W'($urandom_range(0, 1023));
      s.grid_top    = COORD_W'($urandom_range(0, 1023));
      s.cell_width  = pick_size();
      s.cell_height = pick_size();
      s.middle_thr  = pick_threshold(1500);
      s.side_thr    = pick_threshold(1500);
      s.hard_thr    = pick_threshold(3000);
      return s;
   endfunction

   // Offer one pixel transaction until it is taken, then maybe idle for a burst.
   task automatic send_pixel(input req_payload_type p);
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      tally.note_pixel(p);
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Let every pending decision come out and the pipeline empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (tally.pending_decisions.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Write all registers, then one transaction to an unused index.
   task automatic apply_settings(input grid_setting_type s);
      logic [CSR_INDEX_W-1:0] idx [8];
      logic [CSR_DATA_W-1:0]  val [8];
      idx = '{CSR_GRID_LEFT, CSR_GRID_TOP, CSR_CELL_WIDTH, CSR_CELL_HEIGHT,
              CSR_MIDDLE_THR, CSR_SIDE_THR, CSR_HARD_THR, CSR_NO_SUCH_REG};
      val = '{CSR_DATA_W'(s.grid_left), CSR_DATA_W'(s.grid_top),
              CSR_DATA_W'(s.cell_width), CSR_DATA_W'(s.cell_height),
              s.middle_thr, s.side_thr, s.hard_thr, CSR_DATA_W'($urandom)};
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         tally.write_register(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
      active_setting = s;
   endtask

   initial begin : stimulus
      int sent;
      int frame_len;

      tally = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: one middle-column hit in the bottom row, strays just off each edge.
      send_pixel(pixel_at(255, 0, 0, 1'b0));
      send_pixel(pixel_at(255, 1023, 1023, 1'b0));
      send_pixel(pixel_at(255, 14, 40, 1'b0));
      send_pixel(pixel_at(255, 660, 189, 1'b0));
      send_pixel(pixel_at(255, 15, 39, 1'b0));
      send_pixel(pixel_at(255, 15, 190, 1'b0));
      send_pixel(pixel_at(255, 230, 140, 1'b0));
      send_pixel(pixel_at(0, 659, 189, 1'b1));

      // One-pixel cells in the corner; middle threshold above the side one.
      settle();
      apply_settings('{grid_left: 10'd0, grid_top: 10'd0, cell_width: 9'd1, cell_height: 9'd1,
                       middle_thr: 28'd300, side_thr: 28'd100, hard_thr: 28'd400});
      // Bottom corners occupied with a hard obstacle: spin.
      send_pixel(pixel_at(255, 0, 2, 1'b0));
      send_pixel(pixel_at(255, 3, 0, 1'b0));
      send_pixel(pixel_at(255, 2, 2, 1'b0));
      send_pixel(pixel_at(255, 2, 2, 1'b1));
      // Middle row decides over the top row.
      send_pixel(pixel_at(255, 0, 1, 1'b0));
      send_pixel(pixel_at(150, 1, 0, 1'b1));
      // Top row alone decides.
      send_pixel(pixel_at(255, 2, 0, 1'b1));
      // A full middle row with a free bottom row leaves no pattern.
      send_pixel(pixel_at(200, 0, 1, 1'b0));
      send_pixel(pixel_at(200, 1, 1, 1'b0));
      send_pixel(pixel_at(200, 2, 1, 1'b1));
      // Nothing reaches a threshold.
      send_pixel(pixel_at(50, 1, 1, 1'b1));

      // Zero cell width: nothing is counted.
      settle();
      apply_settings('{grid_left: 10'd0, grid_top: 10'd0, cell_width: 9'd0, cell_height: 9'd1,
                       middle_thr: 28'd1, side_thr: 28'd1, hard_thr: 28'd0});
      send_pixel(pixel_at(255, 0, 0, 1'b1));

      // Zero cell height with zero thresholds: every empty cell counts as occupied.
      settle();
      apply_settings('{grid_left: 10'd0, grid_top: 10'd0, cell_width: 9'd1, cell_height: 9'd0,
                       middle_thr: 28'd0, side_thr: 28'd0, hard_thr: 28'd0});
      send_pixel(pixel_at(255, 1, 1, 1'b1));

      // Largest origin, cells and thresholds.
      settle();
      apply_settings('{grid_left: 10'd1023, grid_top: 10'd1023, cell_width: 9'd341,
                       cell_height: 9'd341, middle_thr: SUM_MAX, side_thr: SUM_MAX,
                       hard_thr: SUM_MAX});
      send_pixel(pixel_at(255, 1023, 1023, 1'b1));

      // Random frames under a fresh setting per phase.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         apply_settings(pick_setting());
         if (phase == PRESSURE_PHASE) hold_request = 1'b1;
         if (phase >= RANDOM_PHASES - CALM_PHASES) calm_tail = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (phase == PRESSURE_PHASE) frame_len = $urandom_range(1, 2);
            else if ($urandom_range(0, 7) == 0) frame_len = 40;
            else frame_len = $urandom_range(1, 16);
            for (int k = 0; k < frame_len; k++) begin
               send_pixel(random_pixel(active_setting, k == frame_len - 1));
            end
            sent += frame_len;
         end
      end

      settle();
      if (tally.mismatch_count == 0 && tally.pending_decisions.size() == 0) begin
         $display("[grid_obstacle_detector] OK");
      end else begin
         $display("[grid_obstacle_detector] ERROR");
      end
      $finish;
   end

endmodule
